// ===== design/uvf_pkg.sv =====
package uvf_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DUP   = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic                     op;
      logic signed [DATA_W-1:0] value;
   } uvf_req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] data_out;
   } uvf_rsp_type;

   // control from the sequencer to the compare unit
   typedef struct packed {
      logic clear;
      logic enable;
   } uvf_cmp_ctl_type;

endpackage

// ===== design/unique_value_fifo.sv =====
// Insert: scans the n entries held (at most DEPTH), one entry per cycle, then a drain step
//   and a decide step; the strobe follows the decide step. An empty queue skips the scan.
// Remove: one RAM read; remove from an empty queue: result next cycle, no busy.
// One word in flight at a time; busy is high while a word is being worked.
// The receiver cannot stall: each result is on rsp_data for one cycle with rsp_valid.
// Synchronous active-high reset empties the queue; stored data is not cleared.
module unique_value_fifo #(
   parameter int DEPTH = uvf_pkg::DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  uvf_pkg::uvf_req_type req_data,
   output logic                 rsp_valid,
   output uvf_pkg::uvf_rsp_type rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_DRAIN  = 5'b00100,
      S_DECIDE = 5'b01000,
      S_POP    = 5'b10000
   } state_type;

   state_type                   state_ff, state_in;
   logic [AW-1:0]               head_ff, head_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [AW-1:0]               slot_ff, slot_in;
   logic [CW-1:0]               scan_ff, scan_in;
   logic                        cmp_en_ff, cmp_en_in;
   logic [uvf_pkg::DATA_W-1:0]  value_ff, value_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   uvf_pkg::uvf_rsp_type        rsp_ff, rsp_in;

   logic                        accept;
   logic                        full;
   logic [SW-1:0]               tail_sum;
   logic [SW-1:0]               tail_wrap;
   logic [AW-1:0]               tail;
   logic [AW-1:0]               head_next;
   logic [AW-1:0]               rd_addr;
   logic [uvf_pkg::DATA_W-1:0]  rd_data;
   logic                        wr_en;
   logic                        hit;
   uvf_pkg::uvf_cmp_ctl_type    cmp_ctl;

   assign accept = start && !busy;
   assign full   = (count_ff == CW'(DEPTH));

   assign tail_sum  = SW'(head_ff) + SW'(count_ff);
   assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
   assign tail      = tail_wrap[AW-1:0];
   assign head_next = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);

   assign rd_addr = (state_ff == S_SCAN) ? slot_ff : head_ff;
   assign wr_en   = (state_ff == S_DECIDE) && !hit && !full;

   assign cmp_ctl.clear  = accept;
   assign cmp_ctl.enable = cmp_en_ff;

   uvf_ram #(
      .WIDTH (uvf_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail),
      .wr_data (value_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   uvf_match u_match (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cmp_ctl),
      .key     (value_ff),
      .rd_data (rd_data),
      .hit     (hit)
   );

   always_comb begin
      state_in          = state_ff;
      head_in           = head_ff;
      count_in          = count_ff;
      slot_in           = slot_ff;
      scan_in           = scan_ff;
      value_in          = value_ff;
      cmp_en_in         = (state_ff == S_SCAN);
      rsp_valid_in      = 1'b0;
      rsp_in            = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in = req_data.value;
               slot_in  = head_ff;
               scan_in  = '0;
               if (req_data.op == uvf_pkg::OP_INSERT) begin
                  state_in = (count_ff == '0) ? S_DECIDE : S_SCAN;
               end else if (count_ff == '0) begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.status   = uvf_pkg::ST_EMPTY;
                  rsp_in.data_out = '0;
               end else begin
                  state_in = S_POP;
               end
            end
         end
         S_SCAN: begin
            // advance the read slot, wrapping at the end of the store
            slot_in = (slot_ff == AW'(DEPTH - 1)) ? '0 : slot_ff + AW'(1);
            scan_in = scan_ff + CW'(1);
            if ((scan_ff + CW'(1)) == count_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last compare lands in the hit flag here
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (hit) begin
               rsp_in.status   = uvf_pkg::ST_DUP;
               rsp_in.data_out = '0;
            end else if (full) begin
               rsp_in.status   = uvf_pkg::ST_FULL;
               rsp_in.data_out = '0;
            end else begin
               rsp_in.status   = uvf_pkg::ST_OK;
               rsp_in.data_out = value_ff;
               count_in        = count_ff + CW'(1);
            end
         end
         S_POP: begin
            rsp_valid_in    = 1'b1;
            rsp_in.status   = uvf_pkg::ST_OK;
            rsp_in.data_out = rd_data;
            head_in         = head_next;
            count_in        = count_ff - CW'(1);
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         cmp_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         cmp_en_ff    <= cmp_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      scan_ff  <= scan_in;
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   a_insert_no_early: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.op == uvf_pkg::OP_INSERT) |=> !rsp_valid)
      else $error("insert result before the search");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != uvf_pkg::ST_OK) |-> (rsp_data.data_out == '0))
      else $error("nonzero data on error result");
`endif

endmodule

// ===== design/uvf_ram.sv =====
module uvf_ram #(
   parameter int WIDTH = uvf_pkg::DATA_W,
   parameter int DEPTH = uvf_pkg::DEPTH_DEFAULT,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/uvf_match.sv =====
module uvf_match (
   input  logic                            clock,
   input  logic                            reset,
   input  uvf_pkg::uvf_cmp_ctl_type        ctl,
   input  logic [uvf_pkg::DATA_W-1:0]      key,
   input  logic [uvf_pkg::DATA_W-1:0]      rd_data,
   output logic                            hit
);

   logic hit_ff;
   logic hit_in;

   // accumulate equality over the scanned entries
   always_comb begin
      if (ctl.clear) begin
         hit_in = 1'b0;
      end else begin
         hit_in = hit_ff | (ctl.enable & (rd_data == key));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int DEPTH       = uvf_pkg::DEPTH_DEFAULT;
   localparam int N_RANDOM    = 1726;
   localparam int CALM_TAIL   = 250;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      uvf_pkg::uvf_req_type word;
      bit                   pinned;
      uvf_pkg::uvf_rsp_type rsp;
   } dir_row_type;

   typedef struct {
      bit                   pinned;
      uvf_pkg::uvf_rsp_type rsp;
   } pin_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   uvf_pkg::uvf_req_type req_data = '0;
   logic                 rsp_valid;
   uvf_pkg::uvf_rsp_type rsp_data;

   logic signed [uvf_pkg::DATA_W-1:0] mirror_q[$];
   uvf_pkg::uvf_rsp_type              awaited_rsp_q[$];
   pin_type                           pinned_q[$];
   dir_row_type                       dir_rows[$];
   int                                fail_count  = 0;
   int                                cycle_count = 0;

   unique_value_fifo dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic dir_row_type mk_row(logic op, logic [uvf_pkg::DATA_W-1:0] v, bit pin,
                                          logic [1:0] st, logic [uvf_pkg::DATA_W-1:0] d);
      dir_row_type r;
      r.word.op       = op;
      r.word.value    = v;
      r.pinned        = pin;
      r.rsp.status    = st;
      r.rsp.data_out  = d;
      return r;
   endfunction

   // Apply one accepted word to the mirrored queue and return its response.
   function uvf_pkg::uvf_rsp_type apply_to_mirror(uvf_pkg::uvf_req_type w);
      uvf_pkg::uvf_rsp_type r;
      bit                   found;
      r.status   = uvf_pkg::ST_OK;
      r.data_out = '0;
      found      = 1'b0;
      if (w.op == uvf_pkg::OP_INSERT) begin
         foreach (mirror_q[i])
            if (mirror_q[i] == w.value) found = 1'b1;
         if (found)
            r.status = uvf_pkg::ST_DUP;
         else if (mirror_q.size() >= DEPTH)
            r.status = uvf_pkg::ST_FULL;
         else begin
            mirror_q.push_back(w.value);
            r.data_out = w.value;
         end
      end else if (mirror_q.size() == 0) begin
         r.status = uvf_pkg::ST_EMPTY;
      end else begin
         r.data_out = mirror_q.pop_front();
      end
      return r;
   endfunction

   function void flag(string msg);
      fail_count++;
      if (fail_count <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
   endfunction

   // Compare the result first: it always belongs to a word accepted earlier.
   always @(posedge clock) begin
      uvf_pkg::uvf_rsp_type want;
      pin_type              p;
      if (!reset) begin
         if (rsp_valid) begin
            if (awaited_rsp_q.size() == 0) begin
               flag($sformatf("unrequested word status=%0d data=%h",
                              rsp_data.status, rsp_data.data_out));
            end else begin
               want = awaited_rsp_q.pop_front();
               if (rsp_data.status !== want.status || rsp_data.data_out !== want.data_out)
                  flag($sformatf("status exp %0d got %0d, data exp %h got %h",
                                 want.status, rsp_data.status,
                                 want.data_out, rsp_data.data_out));
            end
         end
         if (start && !busy) begin
            want = apply_to_mirror(req_data);
            p    = pinned_q.pop_front();
            if (p.pinned) want = p.rsp;
            awaited_rsp_q.push_back(want);
         end
      end
   end

   // Hold start high until the word is taken; start stays high for a following word.
   task automatic send_word(uvf_pkg::uvf_req_type w, bit pin, uvf_pkg::uvf_rsp_type pin_rsp);
      pin_type p;
      p.pinned = pin;
      p.rsp    = pin_rsp;
      pinned_q.push_back(p);
      req_data <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      uvf_pkg::uvf_req_type w;
      uvf_pkg::uvf_rsp_type none;
      int                   phase;
      int                   ins_pct;
      bit                   idle_on;
      int                   pick;

      none = '0;
      dir_rows.push_back(mk_row(uvf_pkg::OP_REMOVE, 32'h1234_5678, 1,
                                uvf_pkg::ST_EMPTY, '0));
      dir_rows.push_back(mk_row(uvf_pkg::OP_INSERT, 32'h8000_0000, 1,
                                uvf_pkg::ST_OK, 32'h8000_0000));
      dir_rows.push_back(mk_row(uvf_pkg::OP_INSERT, 32'h7fff_ffff, 1,
                                uvf_pkg::ST_OK, 32'h7fff_ffff));
      dir_rows.push_back(mk_row(uvf_pkg::OP_INSERT, 32'h8000_0000, 1,
                                uvf_pkg::ST_DUP, '0));
      dir_rows.push_back(mk_row(uvf_pkg::OP_INSERT, 32'h0000_0000, 0,
                                uvf_pkg::ST_OK, '0));
      dir_rows.push_back(mk_row(uvf_pkg::OP_INSERT, 32'hffff_ffff, 0,
                                uvf_pkg::ST_OK, '0));
      // newest entry must be searched too
      dir_rows.push_back(mk_row(uvf_pkg::OP_INSERT, 32'hffff_ffff, 1,
                                uvf_pkg::ST_DUP, '0));
      for (int k = 1; k <= DEPTH - 4; k++)
         dir_rows.push_back(mk_row(uvf_pkg::OP_INSERT, k * 32'h0101_0101, 0,
                                   uvf_pkg::ST_OK, '0));
      dir_rows.push_back(mk_row(uvf_pkg::OP_INSERT, 32'h5a5a_5a5a, 1,
                                uvf_pkg::ST_FULL, '0));
      // duplicate wins over full
      dir_rows.push_back(mk_row(uvf_pkg::OP_INSERT, 32'h7fff_ffff, 1,
                                uvf_pkg::ST_DUP, '0));
      dir_rows.push_back(mk_row(uvf_pkg::OP_REMOVE, 32'hdead_beef, 1,
                                uvf_pkg::ST_OK, 32'h8000_0000));
      dir_rows.push_back(mk_row(uvf_pkg::OP_INSERT, 32'h5a5a_5a5a, 0,
                                uvf_pkg::ST_OK, '0));
      dir_rows.push_back(mk_row(uvf_pkg::OP_REMOVE, 32'h0000_0000, 1,
                                uvf_pkg::ST_OK, 32'h7fff_ffff));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].word, dir_rows[i].pinned, dir_rows[i].rsp);
         if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 8));
      end

      // Alternate fill-heavy, drain-heavy and balanced phases so the queue
      // swings between empty and full.
      for (int i = 0; i < N_RANDOM; i++) begin
         phase   = i / 96;
         ins_pct = (phase % 3 == 0) ? 85 : (phase % 3 == 1) ? 25 : 55;
         idle_on = (phase % 4 != 3) && (i < N_RANDOM - CALM_TAIL);
         w.op    = ($urandom_range(0, 99) < ins_pct) ? uvf_pkg::OP_INSERT : uvf_pkg::OP_REMOVE;
         pick    = $urandom_range(0, 99);
         if (w.op == uvf_pkg::OP_REMOVE || pick >= 70) begin
            w.value = $urandom();
         end else if (pick >= 45 && mirror_q.size() > 0) begin
            w.value = mirror_q[$urandom_range(0, mirror_q.size() - 1)];
         end else begin
            w.value = $urandom_range(0, 23);
            if ($urandom_range(0, 1)) w.value = -w.value;
         end
         send_word(w, 1'b0, none);
         if (idle_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 8));
      end

      start <= 1'b0;
      @(posedge clock);
      while (awaited_rsp_q.size() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== unique_value_fifo.f =====
design/uvf_pkg.sv
design/uvf_ram.sv
design/uvf_match.sv
design/unique_value_fifo.sv
tb/tb_top.sv
